>>> sv/dhtu_pkg.sv
// Shared types and constants of the decimal/hex text to integer parser.
package dhtu_pkg;

  // Width of the parsed value; the value port is always 64 bits wide.
  localparam int unsigned ValueBits = 64;
  localparam int unsigned PortBits  = 64;
  localparam int unsigned SumBits   = ValueBits + 5;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CaseBit   = 8'h20;

  typedef enum logic [4:0] {
    PhLead   = 5'b00001,
    PhZero   = 5'b00010,
    PhPrefix = 5'b00100,
    PhDigits = 5'b01000,
    PhTrail  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic       last;
  } item_t;

  typedef struct packed {
    logic                 valid;
    logic                 ok;
    logic [PortBits-1:0]  value;
  } result_t;

endpackage

>>> sv/decimal_hex_text_to_u64_top.sv
// Top level of the streaming decimal/hex text to 64-bit integer parser.
//
//   channel | signals                              | direction
//   in      | in_valid_i/in_ready_o, character_i,  | one character per transfer
//           | has_char_i, last_i                   |
//   out     | out_valid_o/out_ready_i, ok_o,       | one result per text
//           | value_o                              |
//
// One character per cycle unless a last character waits on a held result; a taken last
// character passes the input register, then the digit step into the result register.
// The digit step is one 69-bit shift-add and overflow test per character.
// Reset puts the parser before the first character of a text.
// A held result stalls only a last character; other characters keep flowing.
module decimal_hex_text_to_u64_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    character_i,
  input  logic                          has_char_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic [dhtu_pkg::PortBits-1:0] value_o
);

  dhtu_pkg::item_t   in_item;
  dhtu_pkg::item_t   s1_item;
  dhtu_pkg::result_t res;
  logic              s1_valid;
  logic              s1_advance;
  logic              out_free;
  logic              s1_fire;

  assign in_item.character = character_i;
  assign in_item.has_char  = has_char_i;
  assign in_item.last      = last_i;

  // a last character needs room in the result register
  assign s1_advance = s1_valid && (!s1_item.last || out_free);
  assign s1_fire    = s1_advance;

  dhtu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (s1_advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  dhtu_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .item_i (s1_item),
    .res_o  (res)
  );

  dhtu_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .value_o     (value_o)
  );

  a_fail_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (value_o == '0))
    else $error("failed result carries a nonzero value");

  a_last_blocks_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && s1_item.last && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while a last character is stalled");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && s1_item.last && out_free) |=> out_valid_o)
    else $error("last character did not produce a result");

endmodule

>>> sv/dhtu_in_reg.sv
// Input register stage: holds one character transfer until the parser takes it.
module dhtu_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dhtu_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output dhtu_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  dhtu_pkg::item_t item_q;
  logic            take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/dhtu_parse.sv
// Parser state and the per-character digit step; emits the result on the last item.
module dhtu_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  dhtu_pkg::item_t   item_i,
  output dhtu_pkg::result_t res_o
);

  dhtu_pkg::phase_e                 phase_q, phase_d;
  logic [dhtu_pkg::ValueBits-1:0]   acc_q, acc_d;
  logic                             hex_q, hex_d;
  logic                             failed_q, failed_d;

  logic [7:0]                       c;
  logic [7:0]                       lc;
  logic                             is_space;
  logic                             is_dec;
  logic                             is_hex_letter;
  logic                             digit_ok;
  logic [3:0]                       digit;
  logic [dhtu_pkg::SumBits-1:0]     ext;
  logic [dhtu_pkg::SumBits-1:0]     scaled;
  logic [dhtu_pkg::SumBits-1:0]     sum;
  logic                             ovf;
  logic                             ok;

  assign c  = item_i.character;
  assign lc = c | dhtu_pkg::CaseBit;

  assign is_space = (c == dhtu_pkg::CharSpace) || (c == dhtu_pkg::CharTab) ||
                    (c == dhtu_pkg::CharCr) || (c == dhtu_pkg::CharLf);
  assign is_dec        = (c >= dhtu_pkg::CharZero) && (c <= dhtu_pkg::CharNine);
  assign is_hex_letter = hex_q && (lc >= dhtu_pkg::CharLowA) && (lc <= dhtu_pkg::CharLowF);
  assign digit_ok      = is_dec || is_hex_letter;

  always_comb begin
    if (is_dec) begin
      digit = c[3:0];
    end else begin
      digit = 4'(lc - dhtu_pkg::CharLowA) + 4'd10;
    end
  end

  // acc * base + digit; any bit at or above ValueBits means overflow
  assign ext    = dhtu_pkg::SumBits'(acc_q);
  assign scaled = hex_q ? (ext << 4) : ((ext << 3) + (ext << 1));
  assign sum    = scaled + dhtu_pkg::SumBits'(digit);
  assign ovf    = |sum[dhtu_pkg::SumBits-1:dhtu_pkg::ValueBits];

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    hex_d    = hex_q;
    failed_d = failed_q;
    if (fire_i && item_i.has_char && !failed_q) begin
      unique case (phase_q) inside
        dhtu_pkg::PhLead: begin
          if (is_space) begin
            phase_d = phase_q;
          end else if (c == dhtu_pkg::CharZero) begin
            acc_d   = '0;
            phase_d = dhtu_pkg::PhZero;
          end else if (!digit_ok || ovf) begin
            failed_d = 1'b1;
          end else begin
            acc_d   = sum[dhtu_pkg::ValueBits-1:0];
            phase_d = dhtu_pkg::PhDigits;
          end
        end
        dhtu_pkg::PhZero: begin
          if (c == dhtu_pkg::CharLowX || c == dhtu_pkg::CharUpX) begin
            hex_d   = 1'b1;
            phase_d = dhtu_pkg::PhPrefix;
          end else if (is_space) begin
            phase_d = dhtu_pkg::PhTrail;
          end else if (!digit_ok || ovf) begin
            failed_d = 1'b1;
          end else begin
            acc_d   = sum[dhtu_pkg::ValueBits-1:0];
            phase_d = dhtu_pkg::PhDigits;
          end
        end
        dhtu_pkg::PhPrefix, dhtu_pkg::PhDigits: begin
          if (is_space) begin
            if (phase_q == dhtu_pkg::PhPrefix) begin
              failed_d = 1'b1;
            end else begin
              phase_d = dhtu_pkg::PhTrail;
            end
          end else if (!digit_ok || ovf) begin
            failed_d = 1'b1;
          end else begin
            acc_d   = sum[dhtu_pkg::ValueBits-1:0];
            phase_d = dhtu_pkg::PhDigits;
          end
        end
        dhtu_pkg::PhTrail: begin
          if (!is_space) begin
            failed_d = 1'b1;
          end
        end
        default: begin
          failed_d = 1'b1;
        end
      endcase
    end

    ok = !failed_d && (phase_d == dhtu_pkg::PhZero || phase_d == dhtu_pkg::PhDigits ||
                       phase_d == dhtu_pkg::PhTrail);
    res_o.valid = fire_i && item_i.last;
    res_o.ok    = ok;
    res_o.value = ok ? dhtu_pkg::PortBits'(acc_d) : '0;

    // drop all state once the text ends
    if (fire_i && item_i.last) begin
      phase_d  = dhtu_pkg::PhLead;
      acc_d    = '0;
      hex_d    = 1'b0;
      failed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dhtu_pkg::PhLead;
      acc_q    <= '0;
      hex_q    <= 1'b0;
      failed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      hex_q    <= hex_d;
      failed_q <= failed_d;
    end
  end

endmodule

>>> sv/dhtu_out_reg.sv
// Result register: holds one result until the consumer takes the transfer.
module dhtu_out_reg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dhtu_pkg::result_t               res_i,
  output logic                            free_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            ok_o,
  output logic [dhtu_pkg::PortBits-1:0]   value_o
);

  logic                          valid_q, valid_d;
  logic                          ok_q;
  logic [dhtu_pkg::PortBits-1:0] value_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      ok_q    <= res_i.ok;
      value_q <= res_i.value;
    end
  end

  assign out_valid_o = valid_q;
  assign ok_o        = ok_q;
  assign value_o     = value_q;

endmodule
